// ----- hw/rtl/dcrbl_pkg.sv -----
// Package for the dynamic-contrast backlight duty controller.
// Holds the payload, state and configuration types and the duty constants.
// No dependencies; every other RTL file of the block uses it.
`default_nettype none

package dcrbl_pkg;

    // Request thresholds.
    localparam logic [7:0] LEVEL_MAX    = 8'd240;
    localparam logic [7:0] LEVEL_MIN    = 8'd20;

    // Duty values.
    localparam logic [7:0] DUTY_FULL    = 8'hFF;
    localparam logic [7:0] DUTY_ABS_MIN = 8'h30;
    localparam logic [7:0] DUTY_DCR_MIN = 8'd76;   // 30 percent of full duty

    // Dark-pattern thresholds.
    localparam logic [7:0] DARK_MAX         = 8'd16;
    localparam logic [7:0] ENTER_BRIGHT_ANA = 8'd19;
    localparam logic [7:0] ENTER_BRIGHT_DIG = 8'd17;
    localparam logic [7:0] STAY_BRIGHT_ANA  = 8'd21;
    localparam logic [7:0] STAY_BRIGHT_DIG  = 8'd19;

    // The mid-range map is (x * 179) / 220 with x = level - 20 in 1..220.
    // It is done as (x * MID_RECIP) >> MID_SHIFT, exact over that range.
    localparam int               MID_SHIFT = 16;
    localparam logic [15:0]      MID_RECIP = 16'd53323;
    localparam int               MID_PROD_W = 8 + 16;

    // Configuration register indexes.
    localparam logic CFG_INVERT_DUTY   = 1'b0;
    localparam logic CFG_ANALOG_SOURCE = 1'b1;

    typedef struct packed {
        logic [7:0] backlight_level;
        logic       darkest_pattern;
        logic [7:0] dark_level;
        logic [7:0] bright_level;
    } t_in;

    typedef struct packed {
        logic [7:0] pwm_duty;
        logic       clear_prev_bright;
        logic       cutoff_active;
    } t_out;

    typedef struct packed {
        logic [7:0] brightness;
        logic       cutoff;
    } t_state;

    typedef struct packed {
        logic invert_duty;
        logic analog_source;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hw/rtl/dcrbl_in_stage.sv -----
// Input register of the backlight duty controller.
// Captures one transaction and releases it when the result side can take it.
// Depends on dcrbl_pkg.
`default_nettype none

module dcrbl_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire dcrbl_pkg::t_in i_item,
    input  wire logic           i_take,
    output logic                o_valid,
    output dcrbl_pkg::t_in      o_item
);

    logic           r_vld;
    logic           n_vld;
    dcrbl_pkg::t_in r_item;

    // The register frees up in the same cycle that its item moves on.
    assign o_ready = !r_vld || i_take;

    always_comb begin
        n_vld = r_vld;
        if (i_valid && o_ready) begin
            n_vld = 1'b1;
        end else if (i_take) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- hw/rtl/dcrbl_duty_calc.sv -----
// Next-state and result logic of the backlight duty controller.
// Maps one request onto a brightness and updates the dark-pattern cutoff.
// Depends on dcrbl_pkg.
`default_nettype none

module dcrbl_duty_calc (
    input  wire dcrbl_pkg::t_in    i_item,
    input  wire dcrbl_pkg::t_state i_state,
    input  wire dcrbl_pkg::t_cfg   i_cfg,
    output dcrbl_pkg::t_state      o_state,
    output dcrbl_pkg::t_out        o_result
);

    logic [7:0]                      mid_x;
    logic [dcrbl_pkg::MID_PROD_W-1:0] mid_prod;
    logic [7:0]                      enter_lim;
    logic [7:0]                      stay_lim;
    logic                            dark_ok;
    logic                            clear_prev;
    dcrbl_pkg::t_state               nxt;

    always_comb begin
        mid_x     = i_item.backlight_level - dcrbl_pkg::LEVEL_MIN;
        mid_prod  = dcrbl_pkg::MID_PROD_W'(mid_x) * dcrbl_pkg::MID_PROD_W'(dcrbl_pkg::MID_RECIP);
        enter_lim = i_cfg.analog_source ? dcrbl_pkg::ENTER_BRIGHT_ANA
                                        : dcrbl_pkg::ENTER_BRIGHT_DIG;
        stay_lim  = i_cfg.analog_source ? dcrbl_pkg::STAY_BRIGHT_ANA
                                        : dcrbl_pkg::STAY_BRIGHT_DIG;
        dark_ok   = i_item.dark_level <= dcrbl_pkg::DARK_MAX;
        clear_prev = 1'b0;
        nxt        = i_state;

        if (i_item.backlight_level > dcrbl_pkg::LEVEL_MAX) begin
            nxt.brightness = dcrbl_pkg::DUTY_FULL;
            nxt.cutoff     = 1'b0;
        end else if (i_item.backlight_level <= dcrbl_pkg::LEVEL_MIN) begin
            if (i_item.darkest_pattern) begin
                clear_prev = 1'b1;
                if (!i_state.cutoff) begin
                    // Enter the cutoff on a dark enough frame; duty sits at the floor.
                    if (dark_ok && (i_item.bright_level <= enter_lim)) begin
                        nxt.cutoff = 1'b1;
                    end
                    nxt.brightness = dcrbl_pkg::DUTY_DCR_MIN;
                end else if (dark_ok && (i_item.bright_level <= stay_lim)) begin
                    // Inside the cutoff the duty ramps down one step per frame until it reaches DUTY_ABS_MIN.
                    if (i_state.brightness > dcrbl_pkg::DUTY_ABS_MIN) begin
                        nxt.brightness = i_state.brightness - 8'd1;
                    end
                end else begin
                    nxt.cutoff     = 1'b0;
                    nxt.brightness = dcrbl_pkg::DUTY_DCR_MIN;
                end
            end else begin
                nxt.cutoff     = 1'b0;
                nxt.brightness = dcrbl_pkg::DUTY_DCR_MIN;
            end
        end else begin
            nxt.cutoff     = 1'b0;
            nxt.brightness = mid_prod[dcrbl_pkg::MID_PROD_W-1:dcrbl_pkg::MID_SHIFT]
                             + dcrbl_pkg::DUTY_DCR_MIN;
        end
    end

    assign o_state                    = nxt;
    assign o_result.pwm_duty          = i_cfg.invert_duty ? (dcrbl_pkg::DUTY_FULL - nxt.brightness)
                                                          : nxt.brightness;
    assign o_result.clear_prev_bright = clear_prev;
    assign o_result.cutoff_active     = nxt.cutoff;

endmodule

`default_nettype wire

// ----- hw/rtl/dcr_backlight_duty_controller_top.sv -----
// Dynamic-contrast backlight duty controller. Each input transaction carries one frame's
// backlight request, a darkest-pattern flag and the frame's dark and bright levels; each
// produces exactly one output transaction with the PWM duty, a flag that tells the caller
// to reset its previous bright level, and the current dark-pattern cutoff flag. The block
// takes one transaction per clock cycle while the consumer is ready; each accepted transaction
// passes through the input register and then the result register, with the brightness and
// cutoff state updated at the edge where the result is loaded, so back-to-back frames see
// each other's state. Both sides use valid/ready; the result register lets a new
// transaction enter while an earlier result still waits for the consumer. Configuration
// (invert_duty at index 0, analog_source at index 1) is written through a plain write
// port and must only change while no transaction is in flight.
// Depends on dcrbl_pkg, dcrbl_in_stage and dcrbl_duty_calc.
`default_nettype none

module dcr_backlight_duty_controller_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    // Input channel.
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire dcrbl_pkg::t_in  i_in_data,
    // Output channel.
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output dcrbl_pkg::t_out      o_out_data,
    // Configuration write port.
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic            i_cfg_wdata
);

    logic              s1_vld;
    dcrbl_pkg::t_in    s1_item;
    logic              out_free;
    logic              fire;

    dcrbl_pkg::t_state r_state;
    dcrbl_pkg::t_state n_state;
    dcrbl_pkg::t_cfg   r_cfg;
    dcrbl_pkg::t_out   r_out;
    dcrbl_pkg::t_out   n_out;
    logic              r_out_vld;

    // The result register can be loaded when it is empty or being emptied now.
    assign out_free = !r_out_vld || i_out_ready;
    assign fire     = s1_vld && out_free;

    dcrbl_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .i_take  (out_free),
        .o_valid (s1_vld),
        .o_item  (s1_item)
    );

    dcrbl_duty_calc u_duty_calc (
        .i_item   (s1_item),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Brightness and cutoff state advance only when a transaction leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (fire) begin
                r_state   <= n_state;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dcrbl_pkg::CFG_INVERT_DUTY: begin
                    r_cfg.invert_duty <= i_cfg_wdata;
                end
                dcrbl_pkg::CFG_ANALOG_SOURCE: begin
                    r_cfg.analog_source <= i_cfg_wdata;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/dcrbl_checker.sv -----
// Port-level checker for the backlight duty controller, bound to the top level.
// Depends on dcrbl_pkg and dcr_backlight_duty_controller_top.
`default_nettype none

module dcrbl_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_ready,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire dcrbl_pkg::t_out o_out_data
);

    // A held result stays put until the consumer takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // The cutoff can only be active on a frame that consumed the darkest flag.
    a_cutoff_needs_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.cutoff_active |-> o_out_data.clear_prev_bright)
        else $error("cutoff active without darkest flag consumed");

    // A ready consumer never stalls the input side.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input not ready although output side is ready");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An accepted transaction with a free result path is followed by a valid result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid ##1 i_out_ready |=> o_out_valid)
        else $error("result missing after accepted transaction");

endmodule

bind dcr_backlight_duty_controller_top dcrbl_checker u_dcrbl_checker (.*);

`default_nettype wire

// ----- dv/tb_dcr_backlight_duty_controller_top.sv -----
// Self-checking testbench for the dynamic-contrast backlight duty controller.
// Holds a frame-by-frame duty predictor in a small class, valid/ready drivers and the top module.
// Depends on dcrbl_pkg and dcr_backlight_duty_controller_top.

module tb_dcr_backlight_duty_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dcrbl_pkg::*;

    // Receiver hold-off length for the back-pressure test, in cycles.
    localparam int HOLD_CYCLES  = 80;
    // Cycles without any accepted transaction before the run is declared stuck.
    localparam int STALL_LIMIT  = 2000;
    // Cycles of quiet after the last result before a register write or the verdict.
    localparam int SETTLE_CYCLES = 4;

    // Tracks the brightness and cutoff state of the block, frame by frame, and keeps
    // the duty results that are still owed by the block in acceptance order.
    class backlight_tracker;
        t_out       expected_duties[$];
        logic [7:0] brightness;
        logic       cutoff;
        logic       invert;
        logic       analog;
        int         mismatches;
        int         frames;
        int         results;
        int         cutoff_entries;
        int         floor_frames;

        function new();
            brightness     = 8'd0;
            cutoff         = 1'b0;
            invert         = 1'b0;
            analog         = 1'b0;
            mismatches     = 0;
            frames         = 0;
            results        = 0;
            cutoff_entries = 0;
            floor_frames   = 0;
        endfunction

        function void set_reg(logic idx, logic val);
            if (idx == CFG_INVERT_DUTY) begin
                invert = val;
            end else begin
                analog = val;
            end
        endfunction

        function int pending();
            return expected_duties.size();
        endfunction

        // Advances the state by one accepted frame and queues the duty it must produce.
        function void note_frame(t_in f);
            logic [7:0] lvl;
            logic [7:0] enter_lim;
            logic [7:0] stay_lim;
            logic       dark_ok;
            t_out       r;
            frames++;
            lvl       = (f.backlight_level < LEVEL_MIN) ? LEVEL_MIN : f.backlight_level;
            enter_lim = analog ? ENTER_BRIGHT_ANA : ENTER_BRIGHT_DIG;
            stay_lim  = analog ? STAY_BRIGHT_ANA : STAY_BRIGHT_DIG;
            dark_ok   = (f.dark_level <= DARK_MAX);
            r.clear_prev_bright = 1'b0;
            if (lvl > LEVEL_MAX) begin
                brightness = DUTY_FULL;
                cutoff     = 1'b0;
            end else if (lvl == LEVEL_MIN && f.darkest_pattern) begin
                r.clear_prev_bright = 1'b1;
                if (!cutoff) begin
                    if (dark_ok && f.bright_level <= enter_lim) begin
                        cutoff = 1'b1;
                        cutoff_entries++;
                    end
                    brightness = DUTY_DCR_MIN;
                end else if (dark_ok && f.bright_level <= stay_lim) begin
                    if (brightness > DUTY_ABS_MIN) begin
                        brightness = brightness - 8'd1;
                    end else begin
                        floor_frames++;
                    end
                end else begin
                    cutoff     = 1'b0;
                    brightness = DUTY_DCR_MIN;
                end
            end else if (lvl == LEVEL_MIN) begin
                cutoff     = 1'b0;
                brightness = DUTY_DCR_MIN;
            end else begin
                cutoff     = 1'b0;
                brightness = 8'((int'(lvl - LEVEL_MIN) * int'(DUTY_FULL - DUTY_DCR_MIN))
                                / int'(LEVEL_MAX - LEVEL_MIN) + int'(DUTY_DCR_MIN));
            end
            r.pwm_duty      = invert ? (DUTY_FULL - brightness) : brightness;
            r.cutoff_active = cutoff;
            expected_duties.push_back(r);
        endfunction

        // Compares one accepted result with the oldest duty still owed.
        function void check_duty(t_out got);
            t_out want;
            if (expected_duties.size() == 0) begin
                $error("duty result with no frame waiting: %p", got);
                mismatches++;
                return;
            end
            want = expected_duties.pop_front();
            results++;
            if (got.pwm_duty !== want.pwm_duty) begin
                $error("pwm_duty: expected %0d, actual %0d", want.pwm_duty, got.pwm_duty);
                mismatches++;
            end
            if (got.clear_prev_bright !== want.clear_prev_bright) begin
                $error("clear_prev_bright: expected %0b, actual %0b",
                       want.clear_prev_bright, got.clear_prev_bright);
                mismatches++;
            end
            if (got.cutoff_active !== want.cutoff_active) begin
                $error("cutoff_active: expected %0b, actual %0b",
                       want.cutoff_active, got.cutoff_active);
                mismatches++;
            end
        endfunction
    endclass

    // Every input of the block starts at a known value at time zero.
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_ready = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_idx   = 1'b0;
    logic cfg_wdata = 1'b0;

    logic in_ready;
    logic out_valid;
    t_out out_data;

    // Set by the stimulus to ask the receiver for one long hold-off; cleared by the receiver.
    logic hold_req  = 1'b0;
    // While set, neither side inserts random idle cycles.
    logic calm      = 1'b0;
    int   hold_count = 0;
    int   settings   = 0;
    int   idle_cycles = 0;

    backlight_tracker ledger = new();

    dcr_backlight_duty_controller_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Both monitors sample at the rising edge, where the block also samples. Every input
    // transaction is run through the predictor at the edge that accepts it, and every
    // output transaction is checked against the oldest prediction at its own edge.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            ledger.note_frame(in_data);
        end
        if (rst_n && out_valid && out_ready) begin
            ledger.check_duty(out_data);
        end
    end

    // Either side idles with a probability of about one in four, except while calm is set.
    function automatic bit take_gap();
        return !calm && ($urandom_range(0, 99) < 24);
    endfunction

    function automatic t_in frame(input int lvl, input int drk, input int dk, input int br);
        t_in f;
        f.backlight_level = 8'(lvl);
        f.darkest_pattern = 1'(drk);
        f.dark_level      = 8'(dk);
        f.bright_level    = 8'(br);
        return f;
    endfunction

    // Receiver. Ready changes only at the falling edge. When a hold-off is requested,
    // ready stays low for the whole hold-off, so the pipeline and its result
    // register fill up and the block has to drop its input ready.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
                hold_count++;
            end else begin
                out_ready = calm || ($urandom_range(0, 99) >= 24);
            end
        end
    end

    // Watchdog: ends the run if no transaction moves on either channel for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("dcr_backlight_duty_controller_top: mismatch");
        $finish;
    end

    // Offers one frame. It is entered at a falling edge with valid in whatever state
    // the previous transaction left it, so valid is written once per time step: low
    // during a gap, high with the new payload when the frame is offered. It returns at
    // the falling edge after acceptance with valid still high.
    task automatic send_frame(input t_in f);
        while (take_gap()) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = f;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Drops valid and waits until every owed duty has come back, then lets the
    // pipeline go quiet so that a register write sees an idle block.
    task automatic settle();
        in_valid = 1'b0;
        while (ledger.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes both registers on back-to-back cycles and mirrors them in the predictor.
    task automatic write_cfg(input logic inv, input logic ana);
        cfg_we    = 1'b1;
        cfg_idx   = CFG_INVERT_DUTY;
        cfg_wdata = inv;
        @(negedge clk);
        cfg_idx   = CFG_ANALOG_SOURCE;
        cfg_wdata = ana;
        @(negedge clk);
        cfg_we    = 1'b0;
        ledger.set_reg(CFG_INVERT_DUTY, inv);
        ledger.set_reg(CFG_ANALOG_SOURCE, ana);
        settings++;
    endtask

    // Hand-picked frames under digital thresholds: the clamp limits, the mid-range end
    // points, each way of failing the cutoff entry, entry, a few steps down, losing the
    // cutoff on a bright frame, and clearing it by a frame without the darkest flag, by a
    // mid request and by a high request.
    task automatic run_directed();
        send_frame(frame(0, 0, 0, 0));
        send_frame(frame(255, 1, 255, 255));
        send_frame(frame(241, 0, 128, 7));
        send_frame(frame(240, 0, 0, 255));
        send_frame(frame(21, 1, 0, 0));
        send_frame(frame(130, 0, 60, 200));
        send_frame(frame(20, 1, 17, 0));
        send_frame(frame(20, 1, 16, 18));
        send_frame(frame(20, 1, 16, 17));
        send_frame(frame(5, 1, 0, 19));
        send_frame(frame(0, 1, 16, 19));
        send_frame(frame(20, 1, 16, 20));
        send_frame(frame(20, 1, 0, 0));
        send_frame(frame(19, 1, 3, 5));
        send_frame(frame(19, 1, 3, 5));
        send_frame(frame(20, 0, 0, 0));
        send_frame(frame(20, 1, 0, 0));
        send_frame(frame(22, 1, 0, 0));
        send_frame(frame(20, 1, 0, 0));
        send_frame(frame(241, 1, 0, 0));
        send_frame(frame(20, 1, 255, 255));
    endtask

    // Random frames. Most of them come as runs of dark frames with bright levels around
    // the entry and stay limits, of up to 40 frames so that a run can walk the duty down to its
    // absolute floor and sit there; the rest are unconstrained frames and requests near the clamp edges.
    task automatic run_random(input int count);
        int sent;
        int run_len;
        t_in f;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 55) begin
                run_len = $urandom_range(1, 40);
                repeat (run_len) begin
                    f.backlight_level = 8'($urandom_range(0, 20));
                    f.darkest_pattern = ($urandom_range(0, 9) != 0);
                    f.dark_level      = ($urandom_range(0, 3) == 0) ?
                                        8'($urandom_range(17, 40)) : 8'($urandom_range(0, 16));
                    f.bright_level    = 8'($urandom_range(12, 24));
                    send_frame(f);
                    sent++;
                end
            end else begin
                f = t_in'($urandom);
                case ($urandom_range(0, 3))
                    0: begin
                        f.backlight_level = 8'($urandom_range(18, 22));
                    end
                    1: begin
                        f.backlight_level = 8'($urandom_range(238, 243));
                    end
                    default: begin
                    end
                endcase
                send_frame(f);
                sent++;
            end
        end
    endtask

    // Main sequence: reset once, then one phase per register setting. The block is
    // drained before each setting changes. The second phase starts with the long
    // receiver hold-off while the sender keeps offering frames without gaps, and the
    // third phase runs with no idle cycles on either side at all.
    initial begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_cfg(1'b0, 1'b0);
        run_directed();
        run_random(200);

        settle();
        write_cfg(1'b1, 1'b0);
        calm     = 1'b1;
        hold_req = 1'b1;
        run_random(120);
        calm     = 1'b0;
        run_random(80);

        settle();
        write_cfg(1'b0, 1'b1);
        calm = 1'b1;
        run_random(200);
        calm = 1'b0;

        settle();
        write_cfg(1'b1, 1'b1);
        run_random(200);

        repeat (2) begin
            settle();
            write_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            run_random(100);
        end

        settle();
        $display("Run covered %0d frames and %0d duty results over %0d register settings.",
                 ledger.frames, ledger.results, settings);
        $display("Cutoff entered %0d times, %0d frames held at the duty floor, %0d hold-offs.",
                 ledger.cutoff_entries, ledger.floor_frames, hold_count);
        if (ledger.mismatches == 0) begin
            $display("dcr_backlight_duty_controller_top: match");
        end else begin
            $display("dcr_backlight_duty_controller_top: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/dcrbl_pkg.sv
hw/rtl/dcrbl_in_stage.sv
hw/rtl/dcrbl_duty_calc.sv
hw/rtl/dcr_backlight_duty_controller_top.sv
hw/rtl/dcrbl_checker.sv
dv/tb_dcr_backlight_duty_controller_top.sv
